// File: design/rsl_pkg.sv
// rsl_pkg: shared types and constants for the radial spotlight luma block.
// No dependencies.
`timescale 1ns / 1ps

package rsl_pkg;

	localparam int LUM_W   = 17;
	localparam int CFG_W   = 12;
	localparam int DSQ_W   = 15;   // squared distance inside the radius fits here
	localparam int RAD_W   = 32;   // sqrt radicand, dsq << 16 zero padded
	localparam int ROOT_W  = 16;   // Q8.8 distance
	localparam int REM_W   = 17;   // remainder never exceeds 2*root
	localparam int SLOPE_W = 11;
	localparam int SQRT_STAGES = 8; // two root bits per stage

	localparam logic [DSQ_W-1:0]   RADIUS_SQ  = 15'd25600;
	localparam logic [LUM_W-1:0]   FAR_FACTOR = 17'd13107;
	localparam logic [LUM_W-1:0]   ONE_Q16    = 17'd65536;
	localparam logic [SLOPE_W-1:0] SLOPE_NUM  = 11'd1311;

	// register map
	localparam logic REG_CENTER_X = 1'b0;
	localparam logic REG_CENTER_Y = 1'b1;

	// word moving through the square root stages
	typedef struct packed {
		logic              far;
		logic [LUM_W-1:0]  lum;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} rsl_sq_t;

endpackage

// File: design/rsl_dist.sv
// rsl_dist: stages 1 to 3, offset from center, squares, radius compare.
// Depends on rsl_pkg.
`timescale 1ns / 1ps

module rsl_dist #(
	parameter int COORD_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vin,
	input  logic [COORD_BITS-1:0]             pixel_x,
	input  logic [COORD_BITS-1:0]             pixel_y,
	input  logic [rsl_pkg::LUM_W-1:0]         lum_in,
	input  logic [rsl_pkg::CFG_W-1:0]         center_x,
	input  logic [rsl_pkg::CFG_W-1:0]         center_y,
	output logic                              vout,
	output rsl_pkg::rsl_sq_t                  sq_out
);
	import rsl_pkg::*;

	localparam int DW = ((COORD_BITS > CFG_W - 1) ? COORD_BITS : CFG_W - 1) + 2;
	localparam int AW = DW - 1;
	localparam int SW = 2 * AW + 1;

	logic signed [DW-1:0] px, py, cx, cy, dx, dy;
	logic [AW-1:0]        adx, ady;
	logic [LUM_W-1:0]     lum_sat;
	logic [SW-1:0]        dsq;

	logic                 v_s1, v_s2, v_s3;
	logic [AW-1:0]        adx_s1, ady_s1;
	logic [LUM_W-1:0]     lum_s1, lum_s2, lum_s3;
	logic [2*AW-1:0]      sqx_s2, sqy_s2;
	logic                 far_s3;
	logic [DSQ_W-1:0]     dsq_s3;

	always_comb begin
		px  = signed'({{(DW-COORD_BITS){1'b0}}, pixel_x});
		py  = signed'({{(DW-COORD_BITS){1'b0}}, pixel_y});
		cx  = signed'({{(DW-CFG_W){center_x[CFG_W-1]}}, center_x});
		cy  = signed'({{(DW-CFG_W){center_y[CFG_W-1]}}, center_y});
		dx  = px - cx;
		dy  = py - cy;
		adx = dx[DW-1] ? AW'(-dx) : AW'(dx);
		ady = dy[DW-1] ? AW'(-dy) : AW'(dy);
		lum_sat = (lum_in > ONE_Q16) ? ONE_Q16 : lum_in;
		dsq = SW'(sqx_s2) + SW'(sqy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= adx;
			ady_s1 <= ady;
			lum_s1 <= lum_sat;
			sqx_s2 <= adx_s1 * adx_s1;
			sqy_s2 <= ady_s1 * ady_s1;
			lum_s2 <= lum_s1;
			far_s3 <= dsq > SW'(RADIUS_SQ);
			dsq_s3 <= dsq[DSQ_W-1:0];
			lum_s3 <= lum_s2;
		end
	end

	assign vout = v_s3;
	always_comb begin
		sq_out.far  = far_s3;
		sq_out.lum  = lum_s3;
		sq_out.rad  = {{(RAD_W-DSQ_W-16){1'b0}}, dsq_s3, 16'b0};
		sq_out.rem  = '0;
		sq_out.root = '0;
	end

endmodule

// File: design/rsl_sqrt_stage.sv
// rsl_sqrt_stage: one registered stage of the digit-by-digit square root,
// two root bits per stage. Depends on rsl_pkg.
`timescale 1ns / 1ps

module rsl_sqrt_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vin,
	input  rsl_pkg::rsl_sq_t din,
	output logic             vout,
	output rsl_pkg::rsl_sq_t dout
);
	import rsl_pkg::*;

	rsl_sq_t          nxt;
	logic [REM_W+1:0] r2;
	logic [REM_W+1:0] trial;
	logic             v_sx;
	rsl_sq_t          dat_sx;

	always_comb begin
		nxt = din;
		for (int k = 0; k < 2; k++) begin
			r2    = {nxt.rem, nxt.rad[RAD_W-1 -: 2]};
			trial = {1'b0, nxt.root, 2'b01};
			if (r2 >= trial) begin
				nxt.rem  = REM_W'(r2 - trial);
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = REM_W'(r2);
				nxt.root = {nxt.root[ROOT_W-2:0], 1'b0};
			end
			nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sx <= 1'b0;
		end else if (en) begin
			v_sx <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_sx <= nxt;
		end
	end

	assign vout = v_sx;
	assign dout = dat_sx;

endmodule

// File: design/rsl_scale.sv
// rsl_scale: falloff factor from the Q8.8 distance and the final luminance
// multiply, three register stages. Depends on rsl_pkg.
`timescale 1ns / 1ps

module rsl_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vin,
	input  rsl_pkg::rsl_sq_t          din,
	output logic                      vout,
	output logic [rsl_pkg::LUM_W-1:0] lum_out
);
	import rsl_pkg::*;

	localparam int PW = ROOT_W + SLOPE_W;
	localparam int MW = 2 * LUM_W;

	logic               va_s, vb_s, vc_s;
	logic [PW-1:0]      prod_s12;
	logic               far_s12;
	logic [LUM_W-1:0]   lum_s12, lum_s13, out_s14;
	logic [LUM_W-1:0]   factor_s13;
	logic [MW-1:0]      scaled;

	assign scaled = MW'(lum_s13) * MW'(factor_s13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s <= 1'b0;
			vb_s <= 1'b0;
			vc_s <= 1'b0;
		end else if (en) begin
			va_s <= vin;
			vb_s <= va_s;
			vc_s <= vb_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s12   <= PW'(din.root) * PW'(SLOPE_NUM);
			far_s12    <= din.far;
			lum_s12    <= din.lum;
			factor_s13 <= far_s12 ? FAR_FACTOR : ONE_Q16 - LUM_W'(prod_s12[PW-1:10]);
			lum_s13    <= lum_s12;
			out_s14    <= scaled[16 +: LUM_W];
		end
	end

	assign vout    = vc_s;
	assign lum_out = out_s14;

endmodule

// File: design/radial_spotlight_luma.sv
// radial_spotlight_luma: scales pixel luminance by a radial falloff around a
// configurable center. Fourteen register stages, passed in order by every
// accepted word. One pixel per cycle sustained while the output is not
// stalled; every stage is registered and moves together.
// The whole pipe advances when out_ready is high or the output stage is empty.
// Reset clears all stage valids and sets the center to (0, 0).
// Depends on rsl_pkg, rsl_dist, rsl_sqrt_stage, rsl_scale.
`timescale 1ns / 1ps

module radial_spotlight_luma #(
	parameter int COORD_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// pixel input
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_BITS-1:0]     pixel_x,
	input  logic [COORD_BITS-1:0]     pixel_y,
	input  logic [rsl_pkg::LUM_W-1:0] lum_in,
	// result output
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rsl_pkg::LUM_W-1:0] lum_out,
	// config writes
	input  logic                      cfg_we,
	input  logic                      cfg_addr,
	input  logic [rsl_pkg::CFG_W-1:0] cfg_wdata
);
	import rsl_pkg::*;

	// global stall: every stage moves together, so nothing is dropped or
	// duplicated; bubbles just travel along with their valid bit
	logic en;

	logic [CFG_W-1:0] center_x_q, center_y_q;

	// sqrt chain, entry 0 is the distance stage output
	logic    sv [SQRT_STAGES+1];
	rsl_sq_t sd [SQRT_STAGES+1];

	assign en       = out_ready | ~out_valid;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stages 1-3: |dx|, |dy|, squares, compare against 160^2
	rsl_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (in_valid),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.lum_in   (lum_in),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.vout     (sv[0]),
		.sq_out   (sd[0])
	);

	// stages 4-11: floor(sqrt(dsq << 16)), two result bits per stage
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		rsl_sqrt_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (sv[g]),
			.din    (sd[g]),
			.vout   (sv[g+1]),
			.dout   (sd[g+1])
		);
	end

	// stages 12-14: slope multiply, factor select, luminance multiply
	rsl_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vin     (sv[SQRT_STAGES]),
		.din     (sd[SQRT_STAGES]),
		.vout    (out_valid),
		.lum_out (lum_out)
	);

endmodule

// File: tb/sv/radial_spotlight_luma_test.sv
// radial_spotlight_luma_test: self-checking bench for the radial spotlight block.
// Drives pixel words, predicts the scaled luminance, compares every output word.
// Depends on rsl_pkg and radial_spotlight_luma.
`timescale 1ns / 1ps

module radial_spotlight_luma_test;

	import rsl_pkg::*;

	localparam int COORD_W     = 10;
	localparam int HOLD_CYCLES = 80;    // long output hold-off, fills the pipe
	localparam int DRAIN_LIMIT = 6000;  // cycles allowed for outstanding words to come out
	localparam int TAIL_CYCLES = 20;    // a bit over the depth of the pipe
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 75;

	// directed probe: pin set means the expected word is typed in here
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LUM_W-1:0]   lum;
		logic               pin;
		logic [LUM_W-1:0]   want;
	} probe_t;

	localparam int NUM_PROBES = 20;

	// all probes run with the reset center (0, 0)
	localparam probe_t PROBES [0:NUM_PROBES-1] = '{
		'{10'd0,    10'd0,    17'h10000, 1'b1, 17'd65536},  // at center, full scale
		'{10'd0,    10'd0,    17'h00000, 1'b1, 17'd0},      // black stays black
		'{10'd0,    10'd0,    17'h1FFFF, 1'b1, 17'd65536},  // above one saturates
		'{10'd0,    10'd0,    17'h10001, 1'b1, 17'd65536},  // just above one
		'{10'd1023, 10'd1023, 17'h10000, 1'b1, 17'd13107},  // far corner, flat 0.2
		'{10'd160,  10'd0,    17'h10000, 1'b1, 17'd13096},  // exactly on the radius
		'{10'd0,    10'd160,  17'h10000, 1'b1, 17'd13096},  // radius along y
		'{10'd161,  10'd0,    17'h10000, 1'b1, 17'd13107},  // one past the radius
		'{10'd96,   10'd128,  17'h10000, 1'b0, 17'd0},      // radius hit off-axis
		'{10'd96,   10'd129,  17'h10000, 1'b1, 17'd13107},  // just outside off-axis
		'{10'd1,    10'd0,    17'h10000, 1'b0, 17'd0},
		'{10'd0,    10'd1,    17'h0FFFF, 1'b0, 17'd0},
		'{10'h2AA,  10'h155,  17'h15555, 1'b0, 17'd0},
		'{10'h155,  10'h2AA,  17'h0AAAA, 1'b0, 17'd0},
		'{10'd100,  10'd100,  17'h08000, 1'b0, 17'd0},
		'{10'd113,  10'd113,  17'h10000, 1'b0, 17'd0},      // just inside the radius
		'{10'd1023, 10'd0,    17'h00001, 1'b0, 17'd0},
		'{10'd0,    10'd1023, 17'h1FFFF, 1'b1, 17'd13107},  // far and saturated
		'{10'd50,   10'd20,   17'h0C000, 1'b0, 17'd0},
		'{10'd0,    10'd0,    17'h00001, 1'b1, 17'd1}       // smallest nonzero luma
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [COORD_W-1:0]  pixel_x;
	logic [COORD_W-1:0]  pixel_y;
	logic [LUM_W-1:0]    lum_in;
	logic                out_valid;
	logic                out_ready;
	logic [LUM_W-1:0]    lum_out;
	logic                cfg_we;
	logic                cfg_addr;
	logic [CFG_W-1:0]    cfg_wdata;

	// bench copy of the center registers
	logic signed [CFG_W-1:0] ctr_x;
	logic signed [CFG_W-1:0] ctr_y;

	// travels with the pixel word: typed-in expectation for directed probes
	logic             pin_now;
	logic [LUM_W-1:0] pin_lum;

	logic [LUM_W-1:0] lum_expect_q [$];

	int mismatch_cnt;
	int pixels_in;
	int words_out;
	int inside_cnt;
	int outside_cnt;
	int send_pct;      // chance of a gap before each pixel word
	int recv_pct;      // chance of dropping out_ready on a cycle
	bit hold_req;      // ask the receiver for one long hold-off

	radial_spotlight_luma #(
		.COORD_BITS(COORD_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.lum_in   (lum_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lum_out  (lum_out),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Spotlight falloff: squared distance, Q8.8 root, linear factor inside
	// the radius, flat 0.2 outside, then a floor multiply in Q1.16.
	function automatic logic [LUM_W-1:0] spot_lum(
		input  logic [COORD_W-1:0]     px,
		input  logic [COORD_W-1:0]     py,
		input  logic [LUM_W-1:0]       lum,
		input  logic signed [CFG_W-1:0] cx,
		input  logic signed [CFG_W-1:0] cy,
		output bit                     in_rad
	);
		longint dx;
		longint dy;
		longint unsigned dsq;
		longint unsigned rad;
		longint unsigned root;
		longint unsigned cand;
		longint unsigned factor;
		longint unsigned l;
		dx = longint'(px) - longint'(cx);
		dy = longint'(py) - longint'(cy);
		dsq = longint'(dx * dx + dy * dy);
		l = (lum > ONE_Q16) ? longint'(ONE_Q16) : longint'(lum);
		in_rad = (dsq <= longint'(RADIUS_SQ));
		if (!in_rad) begin
			factor = longint'(FAR_FACTOR);
		end else begin
			// floor square root, one result bit at a time from the top
			rad  = dsq << 16;
			root = 0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				if (cand * cand <= rad)
					root = cand;
			end
			factor = longint'(ONE_Q16) - ((root * longint'(SLOPE_NUM)) >> 10);
		end
		return LUM_W'((l * factor) >> 16);
	endfunction

	// mostly no gap, then short gaps, now and then a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [COORD_W-1:0] near_coord(input logic signed [CFG_W-1:0] c);
		int v;
		v = int'(c) + $urandom_range(0, 340) - 170;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return COORD_W'(v);
	endfunction

	function automatic logic [LUM_W-1:0] pick_lum();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return ONE_Q16;
		if (r < 15)
			return LUM_W'($urandom_range(65537, 131071));
		return LUM_W'($urandom_range(0, 65536));
	endfunction

	task automatic report_mismatch(input string what, input logic [LUM_W-1:0] got,
			input logic [LUM_W-1:0] want);
		$display("ERROR @%0t %s: got %0d want %0d", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Offer one pixel word, starting and ending at a falling edge. A gap
	// lowers valid first; otherwise valid stays high into the next word.
	task automatic push_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [LUM_W-1:0] l, input logic pin, input logic [LUM_W-1:0] want);
		int g;
		g = pick_gap(send_pct);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		lum_in   <= l;
		pin_now  <= pin;
		pin_lum  <= want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Both center registers, one write each, only with the pipe empty.
	task automatic write_center(input logic signed [CFG_W-1:0] cx,
			input logic signed [CFG_W-1:0] cy);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_CENTER_X;
		cfg_wdata <= cx;
		@(negedge clk);
		cfg_addr  <= REG_CENTER_Y;
		cfg_wdata <= cy;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ctr_x = cx;
		ctr_y = cy;
		@(negedge clk);
	endtask

	// Wait for every expected word, bounded; leftovers count as a failure.
	task automatic drain_lum();
		int waited;
		waited = 0;
		while (lum_expect_q.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (lum_expect_q.size() > 0) begin
			report_mismatch("words still expected after drain", 17'd0,
				LUM_W'(lum_expect_q.size()));
			lum_expect_q.delete();
		end
	endtask

	// Monitor: both handshakes are sampled at the rising edge, inputs were
	// settled at the falling edge before it.
	always @(posedge clk) begin
		logic [LUM_W-1:0] want;
		logic [LUM_W-1:0] exp_lum;
		bit               in_rad;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = spot_lum(pixel_x, pixel_y, lum_in, ctr_x, ctr_y, in_rad);
				if (in_rad)
					inside_cnt++;
				else
					outside_cnt++;
				// directed probes carry their own typed-in answer
				lum_expect_q.push_back(pin_now ? pin_lum : want);
				pixels_in++;
			end
			if (out_valid && out_ready) begin
				words_out++;
				if (lum_expect_q.size() == 0) begin
					report_mismatch("output word with nothing expected", lum_out, 17'd0);
				end else begin
					exp_lum = lum_expect_q.pop_front();
					if (lum_out !== exp_lum)
						report_mismatch("lum_out", lum_out, exp_lum);
				end
			end
		end
	end

	// Receiver: random out_ready, plus one long hold-off on request. The
	// hold is counted here so the sender keeps offering words meanwhile.
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				g = pick_gap(recv_pct);
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic signed [CFG_W-1:0] cx;
		logic signed [CFG_W-1:0] cy;
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		pixel_x      = '0;
		pixel_y      = '0;
		lum_in       = '0;
		pin_now      = 1'b0;
		pin_lum      = '0;
		cfg_we       = 1'b0;
		cfg_addr     = REG_CENTER_X;
		cfg_wdata    = '0;
		ctr_x        = '0;
		ctr_y        = '0;
		mismatch_cnt = 0;
		pixels_in    = 0;
		words_out    = 0;
		inside_cnt   = 0;
		outside_cnt  = 0;
		send_pct     = 30;
		recv_pct     = 30;
		hold_req     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed probes against the reset center
		for (int i = 0; i < NUM_PROBES; i++)
			push_pixel(PROBES[i].x, PROBES[i].y, PROBES[i].lum, PROBES[i].pin, PROBES[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			in_valid <= 1'b0;
			@(negedge clk);
			drain_lum();
			repeat (TAIL_CYCLES) @(negedge clk);
			case (p)
				0: begin cx = 12'sd0;     cy = 12'sd0;     end
				1: begin cx = -12'sd2048; cy = -12'sd2048; end
				2: begin cx = 12'sd2047;  cy = 12'sd2047;  end
				3: begin cx = -12'sd2048; cy = 12'sd2047;  end
				4: begin cx = 12'sd2047;  cy = -12'sd2048; end
				5: begin cx = 12'sd512;   cy = 12'sd300;   end
				default: begin
					cx = CFG_W'($urandom_range(0, 1400) - 200);
					cy = CFG_W'($urandom_range(0, 1400) - 200);
				end
			endcase
			write_center(cx, cy);
			// phase 0 runs with no idling at all; phase 5 stalls the input
			// with a long output hold while the sender never gaps
			send_pct = (p == 0 || p == 5) ? 0 : $urandom_range(10, 50);
			recv_pct = (p == 0) ? 0 : $urandom_range(10, 50);
			hold_req = (p == 5);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 1) == 0) begin
					x = near_coord(ctr_x);
					y = near_coord(ctr_y);
				end else begin
					x = COORD_W'($urandom_range(0, 1023));
					y = COORD_W'($urandom_range(0, 1023));
				end
				push_pixel(x, y, pick_lum(), 1'b0, 17'd0);
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		drain_lum();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d pixel words and %0d output words over %0d center settings.",
			pixels_in, words_out, NUM_PHASES + 1);
		$display("Inside the radius: %0d, outside: %0d, mismatches: %0d.",
			inside_cnt, outside_cnt, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/rsl_pkg.sv
design/rsl_dist.sv
design/rsl_sqrt_stage.sv
design/rsl_scale.sv
design/radial_spotlight_luma.sv
tb/sv/radial_spotlight_luma_test.sv
